@@ sv/scfd_pkg.sv @@
// package for the sync crc frame field decoder
// holds sizes, codes, the result layout and the crc-16 helpers; no dependencies
package scfd_pkg;

    localparam int MAX_ROW_BITS  = 1024;
    localparam int PAYLOAD_BYTES = 32;
    localparam int HDR_KEEP      = 13;
    localparam int PAY_BITS      = PAYLOAD_BYTES * 8;
    localparam int CAPTURE_BITS  = PAY_BITS + 16;
    localparam int FRAME_BITS    = (6 + PAYLOAD_BYTES) * 8;
    localparam int CNT_W         = $clog2(MAX_ROW_BITS + 1);
    localparam int CAP_W         = $clog2(CAPTURE_BITS + 1);
    localparam int HDR_AW        = $clog2(HDR_KEEP);

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [31:0] SYNC_RST = 32'hEAEA_EAEA;
    localparam logic [15:0] SEED_RST = 16'hFFFF;

    // configuration register indexes
    localparam logic CFG_SYNC_WORD = 1'b0;
    localparam logic CFG_CRC_SEED  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SHORT  = 2'd1;
    localparam logic [1:0] ST_NOSYNC = 2'd2;
    localparam logic [1:0] ST_CRC    = 2'd3;

    // role codes
    localparam logic [1:0] ROLE_UNKNOWN = 2'd0;
    localparam logic [1:0] ROLE_POLL    = 2'd1;
    localparam logic [1:0] ROLE_RESP    = 2'd2;

    // message types and kinds
    localparam logic [7:0] TYPE_STATUS    = 8'h20;
    localparam logic [7:0] TYPE_CHEMICAL  = 8'h21;
    localparam logic [7:0] TYPE_WATER     = 8'h22;
    localparam logic [7:0] TYPE_SLUDGE    = 8'h23;
    localparam logic [7:0] TYPE_FAULT     = 8'h26;
    localparam logic [7:0] TYPE_HEARTBEAT = 8'h24;

    localparam logic [2:0] KIND_STATUS    = 3'd0;
    localparam logic [2:0] KIND_CHEMICAL  = 3'd1;
    localparam logic [2:0] KIND_WATER     = 3'd2;
    localparam logic [2:0] KIND_SLUDGE    = 3'd3;
    localparam logic [2:0] KIND_FAULT     = 3'd4;
    localparam logic [2:0] KIND_HEARTBEAT = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN   = 3'd6;

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_CAPT = 3'b010,
        PH_DONE = 3'b100
    } t_phase;

    // hunter state after the current bit
    typedef struct packed {
        t_phase phase;
        logic   crc_ok;
    } t_hunt;

    typedef logic [HDR_KEEP-1:0][7:0] t_hdr;

    // first member sits in the highest bits, so status lands at bit 0
    typedef struct packed {
        logic [23:0] remote_cookie;
        logic [23:0] local_cookie;
        logic [7:0]  message_state;
        logic [2:0]  message_kind;
        logic [7:0]  message_type;
        logic [7:0]  message_length;
        logic [7:0]  header_three;
        logic [7:0]  header_zero;
        logic [1:0]  role;
        logic        inverted;
        logic [1:0]  status;
    } t_result;

    function automatic logic [15:0] crc_bit(input logic [15:0] crc, input logic b);
        logic fb;
        fb = crc[15] ^ b;
        return {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    endfunction

    // crc of a 32-bit word, msb first; flat xor network
    function automatic logic [15:0] crc_word(input logic [15:0] seed, input logic [31:0] w);
        logic [15:0] c;
        c = seed;
        for (int i = 31; i >= 0; i--) begin
            c = crc_bit(c, w[i]);
        end
        return c;
    endfunction

    localparam logic [15:0] SYNC_CRC_RST = crc_word(SEED_RST, SYNC_RST);

endpackage

@@ sv/scfd_hunter.sv @@
// one polarity hunter: captures payload and trailer after a sync match
// runs the crc over the payload and keeps header bytes; uses scfd_pkg
module scfd_hunter
    import scfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_bit,
    input  logic        i_match,
    input  logic        i_row_end,
    input  logic [15:0] i_sync_crc,
    output t_hunt       o_state,
    output t_hdr        o_hdr
);

    t_phase           r_phase, n_phase;
    logic [CAP_W-1:0] r_cnt, n_cnt;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_byte, n_byte;
    logic [15:0]      r_trl, n_trl;
    logic             hdr_wr;
    t_hdr             r_hdr;

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_crc   = r_crc;
        n_byte  = r_byte;
        n_trl   = r_trl;
        hdr_wr  = 1'b0;
        case (r_phase)
            PH_CAPT: begin
                if (r_cnt < CAP_W'(PAY_BITS)) begin
                    n_crc  = crc_bit(r_crc, i_bit);
                    n_byte = {r_byte[6:0], i_bit};
                    hdr_wr = (r_cnt[2:0] == 3'b111) &&
                             (r_cnt[CAP_W-1:3] < (CAP_W-3)'(HDR_KEEP));
                end else begin
                    n_trl = {r_trl[14:0], i_bit};
                end
                n_cnt = r_cnt + 1'b1;
                if (n_cnt >= CAP_W'(CAPTURE_BITS)) begin
                    n_phase = PH_DONE;
                end
            end
            PH_HUNT: begin
                if (i_match) begin
                    n_phase = PH_CAPT;
                    n_cnt   = '0;
                    n_crc   = i_sync_crc;
                    n_byte  = '0;
                    n_trl   = '0;
                end
            end
            default: ;
        endcase
    end

    assign o_state.phase  = n_phase;
    assign o_state.crc_ok = (n_crc == n_trl);
    assign o_hdr          = r_hdr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_cnt   <= '0;
            r_crc   <= '0;
            r_byte  <= '0;
            r_trl   <= '0;
        end else if (i_step) begin
            if (i_row_end) begin
                r_phase <= PH_HUNT;
                r_cnt   <= '0;
                r_crc   <= '0;
                r_byte  <= '0;
                r_trl   <= '0;
            end else begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_crc   <= n_crc;
                r_byte  <= n_byte;
                r_trl   <= n_trl;
            end
        end
    end

    // header bytes, no reset: only read once the capture is done
    always_ff @(posedge i_clk) begin
        if (i_step && hdr_wr) begin
            r_hdr[r_cnt[3 +: HDR_AW]] <= n_byte;
        end
    end

endmodule

@@ sv/scfd_decode.sv @@
// header field decoder: turns the chosen hunter's header bytes into result fields
// zeroes everything but status when the frame is not ok; uses scfd_pkg
module scfd_decode
    import scfd_pkg::*;
(
    input  t_hdr       i_hdr,
    input  logic       i_inverted,
    input  logic [1:0] i_status,
    output t_result    o_result
);

    logic [7:0] len;
    logic [7:0] mtype;
    logic [2:0] kind;

    assign len   = i_hdr[10];
    assign mtype = i_hdr[11];

    always_comb begin
        case (mtype)
            TYPE_STATUS:    kind = KIND_STATUS;
            TYPE_CHEMICAL:  kind = KIND_CHEMICAL;
            TYPE_WATER:     kind = KIND_WATER;
            TYPE_SLUDGE:    kind = KIND_SLUDGE;
            TYPE_FAULT:     kind = KIND_FAULT;
            TYPE_HEARTBEAT: kind = KIND_HEARTBEAT;
            default:        kind = KIND_UNKNOWN;
        endcase
    end

    always_comb begin
        o_result        = '0;
        o_result.status = i_status;
        if (i_status == ST_OK) begin
            o_result.inverted       = i_inverted;
            o_result.role           = i_hdr[3][7] ? ROLE_RESP :
                                      (i_hdr[3][6] ? ROLE_POLL : ROLE_UNKNOWN);
            o_result.header_zero    = i_hdr[0];
            o_result.header_three   = i_hdr[3];
            o_result.message_length = len;
            o_result.message_type   = (len != 8'd0) ? mtype : 8'd0;
            o_result.message_kind   = (len != 8'd0) ? kind : KIND_UNKNOWN;
            o_result.message_state  = (len >= 8'd2) ? i_hdr[12] : 8'd0;
            o_result.local_cookie   = {i_hdr[4], i_hdr[5], i_hdr[6]};
            o_result.remote_cookie  = {i_hdr[7], i_hdr[8], i_hdr[9]};
        end
    end

endmodule

@@ sv/sync_crc_frame_field_decoder.sv @@
// top level of the sync crc frame field decoder
// instantiates two scfd_hunter and one scfd_decode; uses scfd_pkg
//
// usage
//   slave stream: one decoded line bit per request in s_axis_tdata[0],
//   s_axis_tlast marks the final bit of a row
//   master stream: one result per row, 96 bits of tdata, given when the
//   bit with tlast set has gone through
//   config channel: index 0 sync word, index 1 crc seed; always ready,
//   write only while the stream side is idle
//   result path: a row-end bit goes through the input register, then the
//   state update and result register; a stalled output slot can hold it
//   throughput: one bit per cycle while no row-end bit waits for the slot;
//   the per-bit shift, crc step and sync compare are all done in the single stage behind the input register
//   reset: sync word 0xeaeaeaea, seed 0xffff, both hunters back to hunting,
//   row counter and history cleared; no clearing pass is needed
//   stall: a held result keeps the output register; bits that cause no
//   result keep flowing, and only a row-end bit waits for the slot
module sync_crc_frame_field_decoder
    import scfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] data_bit, [7:1] zero
    input  logic        s_axis_tlast,   // row_last
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // status, inverted, role, header_zero,
                                        // header_three, message_length,
                                        // message_type, message_kind,
                                        // message_state, local_cookie,
                                        // remote_cookie
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [31:0]      r_sync;
    logic [15:0]      r_seed;
    logic [15:0]      r_sync_crc;

    logic             r_in_valid;
    logic             r_in_bit;
    logic             r_in_last;

    logic [CNT_W-1:0] r_count, n_count;
    logic [31:0]      r_recent, n_recent;

    logic             r_out_valid;
    t_result          r_out;

    logic             adv;
    logic             match0, match1;
    t_hunt            hunt0, hunt1;
    t_hdr             hdr0, hdr1;
    logic             sel;
    logic [1:0]       status;
    t_result          result;

    // config registers, crc of the sync word precomputed from them
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync     <= SYNC_RST;
            r_seed     <= SEED_RST;
            r_sync_crc <= SYNC_CRC_RST;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SYNC_WORD: r_sync <= i_cfg_data;
                    CFG_CRC_SEED:  r_seed <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            r_sync_crc <= crc_word(r_seed, r_sync);
        end
    end

    // stage advances unless a row-end bit meets a full, stalled output slot
    assign adv = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_bit  <= s_axis_tdata[0];
            r_in_last <= s_axis_tlast;
        end
    end

    // row bit counter saturates, history shifts msb first
    assign n_count  = (r_count < CNT_W'(MAX_ROW_BITS)) ? r_count + 1'b1 : r_count;
    assign n_recent = {r_recent[30:0], r_in_bit};
    assign match0   = (n_count >= CNT_W'(32)) && (n_recent == r_sync);
    assign match1   = (n_count >= CNT_W'(32)) && (n_recent == ~r_sync);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_recent <= '0;
        end else if (adv) begin
            if (r_in_last) begin
                r_count  <= '0;
                r_recent <= '0;
            end else begin
                r_count  <= n_count;
                r_recent <= n_recent;
            end
        end
    end

    // normal polarity hunter
    scfd_hunter u_hunt0 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (adv),
        .i_bit      (r_in_bit),
        .i_match    (match0),
        .i_row_end  (r_in_last),
        .i_sync_crc (r_sync_crc),
        .o_state    (hunt0),
        .o_hdr      (hdr0)
    );

    // inverted polarity hunter, sees every bit flipped
    scfd_hunter u_hunt1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (adv),
        .i_bit      (~r_in_bit),
        .i_match    (match1),
        .i_row_end  (r_in_last),
        .i_sync_crc (r_sync_crc),
        .o_state    (hunt1),
        .o_hdr      (hdr1)
    );

    // normal polarity wins whenever it saw its sync
    assign sel = (hunt0.phase == PH_HUNT);

    always_comb begin
        if (n_count < CNT_W'(FRAME_BITS)) begin
            status = ST_SHORT;
        end else if (hunt0.phase == PH_HUNT && hunt1.phase == PH_HUNT) begin
            status = ST_NOSYNC;
        end else if ((sel ? hunt1.phase : hunt0.phase) != PH_DONE) begin
            status = ST_SHORT;
        end else if (!(sel ? hunt1.crc_ok : hunt0.crc_ok)) begin
            status = ST_CRC;
        end else begin
            status = ST_OK;
        end
    end

    scfd_decode u_decode (
        .i_hdr      (sel ? hdr1 : hdr0),
        .i_inverted (sel),
        .i_status   (status),
        .o_result   (result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

@@ tb/sync_crc_frame_field_decoder_tb.sv @@
`timescale 1ns / 1ps
// testbench for sync_crc_frame_field_decoder: bit rows in, one decoded row result out
// depends on scfd_pkg and the block itself; a scoreboard class predicts each row result
module sync_crc_frame_field_decoder_tb;

    import scfd_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int HOLD_CYCLES = 400;

    // predicts the decoded result of every row from the accepted bits and checks it
    class frame_scoreboard;
        logic [31:0]  anchor;
        logic [15:0]  seed;
        int unsigned  bit_count;
        logic [31:0]  history;
        t_phase       phase [2];
        int unsigned  taken [2];
        logic [15:0]  crc [2];
        logic [7:0]   shift_byte [2];
        logic [15:0]  tail [2];
        logic [7:0]   hdr [2][HDR_KEEP];
        t_result      awaited_results [$];
        int unsigned  mismatches;
        int unsigned  seen;

        function new();
            anchor = SYNC_RST;
            seed = SEED_RST;
            mismatches = 0;
            seen = 0;
            foreach (hdr[h, k]) hdr[h][k] = 8'h00;
            clear_row();
        endfunction

        static function logic [15:0] crc_step(logic [15:0] c, logic b);
            return {c[14:0], 1'b0} ^ ((c[15] ^ b) ? CRC_POLY : 16'h0000);
        endfunction

        function void clear_row();
            bit_count = 0;
            history = '0;
            for (int h = 0; h < 2; h++) begin
                phase[h] = PH_HUNT;
                taken[h] = 0;
                crc[h] = '0;
                shift_byte[h] = '0;
                tail[h] = '0;
            end
        endfunction

        function void write_reg(logic idx, logic [31:0] value);
            if (idx == CFG_SYNC_WORD) anchor = value;
            else seed = value[15:0];
        endfunction

        // hunter found its pattern: crc runs over the four sync bytes first
        function void open_capture(int h);
            logic [15:0] c;
            c = seed;
            for (int i = 31; i >= 0; i--) c = crc_step(c, anchor[i]);
            phase[h] = PH_CAPT;
            taken[h] = 0;
            crc[h] = c;
            shift_byte[h] = '0;
            tail[h] = '0;
        endfunction

        function void capture(int h, logic b);
            if (taken[h] < PAY_BITS) begin
                crc[h] = crc_step(crc[h], b);
                shift_byte[h] = {shift_byte[h][6:0], b};
                if (taken[h] % 8 == 7 && taken[h] / 8 < HDR_KEEP)
                    hdr[h][taken[h] / 8] = shift_byte[h];
            end else begin
                tail[h] = {tail[h][14:0], b};
            end
            taken[h]++;
            if (taken[h] >= CAPTURE_BITS) phase[h] = PH_DONE;
        endfunction

        function logic [2:0] kind_of_type(logic [7:0] t);
            case (t)
                TYPE_STATUS:    return KIND_STATUS;
                TYPE_CHEMICAL:  return KIND_CHEMICAL;
                TYPE_WATER:     return KIND_WATER;
                TYPE_SLUDGE:    return KIND_SLUDGE;
                TYPE_FAULT:     return KIND_FAULT;
                TYPE_HEARTBEAT: return KIND_HEARTBEAT;
                default:        return KIND_UNKNOWN;
            endcase
        endfunction

        // one accepted bit; a row end queues the expected result
        function void note_bit(logic b, logic last);
            t_result r;
            int sel;
            logic [7:0] len;
            if (bit_count < MAX_ROW_BITS) bit_count++;
            for (int h = 0; h < 2; h++)
                if (phase[h] == PH_CAPT) capture(h, b ^ (h == 1));
            history = {history[30:0], b};
            if (bit_count >= 32) begin
                if (phase[0] == PH_HUNT && history == anchor) open_capture(0);
                if (phase[1] == PH_HUNT && history == ~anchor) open_capture(1);
            end
            if (!last) return;
            r = '0;
            sel = -1;
            if (phase[0] != PH_HUNT) sel = 0;
            else if (phase[1] != PH_HUNT) sel = 1;
            if (bit_count < FRAME_BITS) begin
                r.status = ST_SHORT;
            end else if (sel < 0) begin
                r.status = ST_NOSYNC;
            end else if (phase[sel] != PH_DONE) begin
                r.status = ST_SHORT;
            end else if (crc[sel] != tail[sel]) begin
                r.status = ST_CRC;
            end else begin
                len = hdr[sel][10];
                r.status = ST_OK;
                r.inverted = (sel == 1);
                r.role = hdr[sel][3][7] ? ROLE_RESP : (hdr[sel][3][6] ? ROLE_POLL : ROLE_UNKNOWN);
                r.header_zero = hdr[sel][0];
                r.header_three = hdr[sel][3];
                r.message_length = len;
                r.message_type = (len >= 1) ? hdr[sel][11] : 8'h00;
                r.message_kind = (len >= 1) ? kind_of_type(hdr[sel][11]) : KIND_UNKNOWN;
                r.message_state = (len >= 2) ? hdr[sel][12] : 8'h00;
                r.local_cookie = {hdr[sel][4], hdr[sel][5], hdr[sel][6]};
                r.remote_cookie = {hdr[sel][7], hdr[sel][8], hdr[sel][9]};
            end
            awaited_results.push_back(r);
            clear_row();
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) $display("mismatch: %s", msg);
        endfunction

        function void cmp(string name, logic [23:0] want, logic [23:0] got);
            if (got !== want)
                report($sformatf("result %0d %s expected %h got %h", seen, name, want, got));
        endfunction

        function void check_result(logic [95:0] raw);
            t_result got;
            t_result want;
            got = raw;
            if (awaited_results.size() == 0) begin
                report($sformatf("result %0d arrived with none pending: %h", seen, raw));
                seen++;
                return;
            end
            want = awaited_results.pop_front();
            cmp("status", 24'(want.status), 24'(got.status));
            cmp("inverted", 24'(want.inverted), 24'(got.inverted));
            cmp("role", 24'(want.role), 24'(got.role));
            cmp("header_zero", 24'(want.header_zero), 24'(got.header_zero));
            cmp("header_three", 24'(want.header_three), 24'(got.header_three));
            cmp("message_length", 24'(want.message_length), 24'(got.message_length));
            cmp("message_type", 24'(want.message_type), 24'(got.message_type));
            cmp("message_kind", 24'(want.message_kind), 24'(got.message_kind));
            cmp("message_state", 24'(want.message_state), 24'(got.message_state));
            cmp("local_cookie", want.local_cookie, got.local_cookie);
            cmp("remote_cookie", want.remote_cookie, got.remote_cookie);
            seen++;
        endfunction

        function void close();
            if (awaited_results.size() != 0)
                report($sformatf("%0d results never arrived", awaited_results.size()));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [0] data_bit, [7:1] zero
    logic        s_axis_tlast = 1'b0; // row_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;        // status, inverted, role, header_zero, header_three,
                                      // message_length, message_type, message_kind,
                                      // message_state, local_cookie, remote_cookie
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_SYNC_WORD;
    logic [31:0] i_cfg_data = '0;

    frame_scoreboard sb = new();

    // bits of the row being built, and the payload bytes behind the next frame
    logic        line_bits [$];
    logic [7:0]  payload [PAYLOAD_BYTES];
    int          burst_left = 0;
    bit          long_hold = 1'b0;

    sync_crc_frame_field_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // every accepted result goes against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // one bit request; the sender idles between bursts, some of them long
    task automatic send_bit(input logic b, input logic last);
        if (burst_left == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge i_clk);
            burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(600, 200)
                                                     : $urandom_range(20, 1);
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {7'b0, b};
        s_axis_tlast = last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_bit(b, last);
        @(negedge i_clk);
    endtask

    task automatic send_row();
        foreach (line_bits[i]) send_bit(line_bits[i], i == line_bits.size() - 1);
        line_bits.delete();
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // registers change only once the last row has drained out of the pipeline
    task automatic reconfigure(input logic [31:0] sync_value, input logic [15:0] seed_value);
        s_axis_tvalid = 1'b0;
        while (sb.awaited_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        write_reg(CFG_SYNC_WORD, sync_value);
        write_reg(CFG_CRC_SEED, {16'h0000, seed_value});
    endtask

    task automatic add_bits(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) line_bits.push_back(v[i]);
    endtask

    task automatic add_noise(input int n);
        repeat (n) line_bits.push_back(1'($urandom_range(1, 0)));
    endtask

    // random bytes, with the length and type bytes pulled toward the decoded cases
    task automatic random_payload();
        logic [7:0] known [6] = '{TYPE_STATUS, TYPE_CHEMICAL, TYPE_WATER,
                                  TYPE_SLUDGE, TYPE_FAULT, TYPE_HEARTBEAT};
        foreach (payload[k]) payload[k] = 8'($urandom_range(255, 0));
        case ($urandom_range(3, 0))
            0: payload[10] = 8'd0;
            1: payload[10] = 8'd1;
            2: payload[10] = 8'd2;
            default: ;
        endcase
        if ($urandom_range(3, 0) != 0) payload[11] = known[$urandom_range(5, 0)];
    endtask

    task automatic shape_payload(input logic [7:0] flags, input logic [7:0] len,
                                 input logic [7:0] typ);
        random_payload();
        payload[3] = flags;
        payload[10] = len;
        payload[11] = typ;
    endtask

    // sync word, payload and trailer; a broken trailer has one bit flipped;
    // an inverted frame is the same frame with every line bit flipped
    task automatic add_frame(input bit inv, input bit bad_crc);
        logic [15:0] c;
        int start;
        start = line_bits.size();
        c = sb.seed;
        for (int i = 31; i >= 0; i--) c = frame_scoreboard::crc_step(c, sb.anchor[i]);
        add_bits(sb.anchor, 32);
        foreach (payload[k]) begin
            for (int i = 7; i >= 0; i--) c = frame_scoreboard::crc_step(c, payload[k][i]);
            add_bits({24'h000000, payload[k]}, 8);
        end
        if (bad_crc) c[$urandom_range(15, 0)] ^= 1'b1;
        add_bits({16'h0000, c}, 16);
        if (inv)
            for (int i = start; i < line_bits.size(); i++) line_bits[i] = ~line_bits[i];
    endtask

    task automatic directed_rows();
        // lone row-end bit
        line_bits.push_back(1'b1);
        send_row();
        // shortest frame, no preamble: response role
        shape_payload(8'h80, 8'd2, TYPE_STATUS);
        add_frame(0, 0);
        send_row();
        // short rows against a held output: only row ends need the slot
        long_hold = 1'b1;
        repeat (14) begin
            add_noise($urandom_range(6, 1));
            send_row();
        end
        // new anchor and seed, then an inverted frame behind some noise: poll role,
        // one body byte so the state reads as zero
        reconfigure($urandom(), 16'($urandom_range(65535, 0)));
        add_noise(8);
        shape_payload(8'h40, 8'd1, TYPE_CHEMICAL);
        add_frame(1, 0);
        add_noise(3);
        send_row();
        // short noise rows
        repeat (10) begin
            add_noise($urandom_range(24, 1));
            send_row();
        end
    endtask

    // receiver: stall rate changes over spans of random length; on request
    // it holds off for a long stretch so that the input side backs up
    initial begin
        int stall_pct;
        int span;
        forever begin
            case ($urandom_range(3, 0))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
            span = $urandom_range(300, 30);
            repeat (span) begin
                @(negedge i_clk);
                if (long_hold) begin
                    m_axis_tready = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                    long_hold = 1'b0;
                end
                m_axis_tready = ($urandom_range(99, 0) >= stall_pct);
            end
        end
    end

    // generous limit against a hung block
    initial begin
        #(CLK_PERIOD * 2_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_rows();

        s_axis_tvalid = 1'b0;
        while (sb.awaited_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        sb.close();
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
